>>> design/rational_sum_accumulator_unit_macros.svh
// ----------------------------------------------------------------------------
// rational sum accumulator assertion macros
// property wrappers for the accumulator unit design file
// ----------------------------------------------------------------------------
`ifndef RATIONAL_SUM_ACCUMULATOR_UNIT_MACROS_SVH
`define RATIONAL_SUM_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsa assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsa assertion failed");

`else

`define RSA_ASSERT_IMPLY(label, ante, cons)
`define RSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// types, constants and helpers for the rational sum accumulator
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int ACC_W     = 64;
	localparam int HALF_W    = 32;
	localparam int DIV_CNT_W = 6;

	localparam logic [ACC_W-1:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
	localparam logic [ACC_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [ACC_W-1:0] ACC_ONE   = 64'd1;

	// sequencer states, one-hot
	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_STEP = 12'b0000_0000_0010,
		S_MUL  = 12'b0000_0000_0100,
		S_ADD  = 12'b0000_0000_1000,
		S_END  = 12'b0000_0001_0000,
		S_GCD  = 12'b0000_0010_0000,
		S_GREM = 12'b0000_0100_0000,
		S_QN   = 12'b0000_1000_0000,
		S_QD   = 12'b0001_0000_0000,
		S_EMIT = 12'b0010_0000_0000
	} state_t;

	// which cross product the shared multiplier is working on
	typedef enum logic [1:0] {
		PROD_NUM_D = 2'd0,
		PROD_DEN_N = 2'd1,
		PROD_DEN_D = 2'd2
	} prod_sel_t;

	// sub-steps of one 64 x n product
	typedef enum logic [1:0] {
		MSTEP_LO  = 2'd0,
		MSTEP_HI  = 2'd1,
		MSTEP_SUM = 2'd2,
		MSTEP_FIX = 2'd3
	} mstep_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [ACC_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] quotient;
		logic [ACC_W-1:0] remainder;
	} div_rsp_t;

	// magnitude of a two's complement word, as unsigned
	function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] x);
		return x[ACC_W-1] ? (~x + ACC_ONE) : x;
	endfunction

	// signed wrap of a + b giving r
	function automatic logic add_ovf(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b,
			input logic [ACC_W-1:0] r);
		return (a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]);
	endfunction

endpackage

>>> design/rational_sum_accumulator_unit.sv
// ----------------------------------------------------------------------------
// rational_sum_accumulator_unit
// sums signed integers or fractions, reduces fraction sums by gcd on the last beat
// ----------------------------------------------------------------------------
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    numerator_in, denominator_in, last_item
// out       out   out_valid / out_ready  sum_numerator, sum_denominator,
//                                        overflow_seen, zero_divisor
// cfg       in    cfg_we                 cfg_wdata (number_mode)
//
// integer beat: idle, step and end states, and the emit state on a last beat;
// fraction beat: the shared 32 x INPUT_WIDTH multiplier does three cross
// products in 4 steps each, then an add state (a first beat skips both). a last
// fraction beat adds euclid remainder steps and the two reducing divisions, all
// on the one 64-bit divider, then the emit state; a zero gcd skips the divisions.
// in_ready is high only in idle; a result waits in the output register while
// the next beat is taken, and a new result stalls until that register is free.
// reset clears control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "rational_sum_accumulator_unit_macros.svh"

module rational_sum_accumulator_unit import rsa_pkg::*; #(
	parameter int INPUT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [INPUT_WIDTH-1:0] numerator_in,
	input  logic signed [INPUT_WIDTH-1:0] denominator_in,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ACC_W-1:0]       sum_numerator,
	output logic signed [ACC_W-1:0]       sum_denominator,
	output logic                          overflow_seen,
	output logic                          zero_divisor
);

	localparam int MUL_W = HALF_W + INPUT_WIDTH;
	localparam int MAG_W = ACC_W + INPUT_WIDTH;
	localparam int EXT_W = ACC_W - INPUT_WIDTH;

	state_t    state_q;
	prod_sel_t prod_q;
	mstep_t    mstep_q;
	logic      have_first_q;
	logic      ovf_q;
	logic      mode_q;
	logic      frac_q;
	logic      out_valid_q;

	logic [INPUT_WIDTH-1:0] item_n_q;
	logic [INPUT_WIDTH-1:0] item_d_q;
	logic                   last_q;
	logic [ACC_W-1:0]       acc_num_q;
	logic [ACC_W-1:0]       acc_den_q;
	logic [MUL_W-1:0]       mul_q;
	logic [MUL_W-1:0]       low_q;
	logic [MAG_W-1:0]       pmag_q;
	logic                   neg_q;
	logic [ACC_W-1:0]       p1_q;
	logic [ACC_W-1:0]       p2_q;
	logic [ACC_W-1:0]       gx_q;
	logic [ACC_W-1:0]       gy_q;
	logic [ACC_W-1:0]       res_num_q;
	logic [ACC_W-1:0]       res_den_q;
	logic                   res_zdiv_q;
	logic [ACC_W-1:0]       out_num_q;
	logic [ACC_W-1:0]       out_den_q;
	logic                   out_ovf_q;
	logic                   out_zdiv_q;

	logic [ACC_W-1:0]       n_ext;
	logic [ACC_W-1:0]       d_ext;
	logic [ACC_W-1:0]       a_sel;
	logic [ACC_W-1:0]       b_sel;
	logic [ACC_W-1:0]       a_mag;
	logic [ACC_W-1:0]       b_mag;
	logic [HALF_W-1:0]      mul_a;
	logic [INPUT_WIDTH-1:0] mul_b;
	logic [MUL_W-1:0]       mul_p;
	logic [ACC_W-1:0]       pv;
	logic                   p_ovf;
	logic [ACC_W-1:0]       int_sum;
	logic [ACC_W-1:0]       pp_sum;
	logic [ACC_W-1:0]       rem_signed;
	logic                   q_neg;
	logic [ACC_W-1:0]       q_val;
	logic                   q_ovf;
	logic                   emit_free;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	// sign extension of the held beat
	assign n_ext = {{EXT_W{item_n_q[INPUT_WIDTH-1]}}, item_n_q};
	assign d_ext = {{EXT_W{item_d_q[INPUT_WIDTH-1]}}, item_d_q};

	// operand select for the current cross product
	always_comb begin
		case (prod_q)
			PROD_NUM_D: begin
				a_sel = acc_num_q;
				b_sel = d_ext;
			end
			PROD_DEN_N: begin
				a_sel = acc_den_q;
				b_sel = n_ext;
			end
			PROD_DEN_D: begin
				a_sel = acc_den_q;
				b_sel = d_ext;
			end
			default: begin
				a_sel = acc_den_q;
				b_sel = d_ext;
			end
		endcase
	end

	// shared multiplier on magnitudes, one 32-bit half of a per cycle
	assign a_mag = mag64(a_sel);
	assign b_mag = mag64(b_sel);
	assign mul_b = b_mag[INPUT_WIDTH-1:0];
	assign mul_a = (mstep_q == MSTEP_LO) ? a_mag[HALF_W-1:0] : a_mag[ACC_W-1:HALF_W];
	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

	// signed product and its wrap check
	assign pv    = neg_q ? (~pmag_q[ACC_W-1:0] + ACC_ONE) : pmag_q[ACC_W-1:0];
	assign p_ovf = (|pmag_q[MAG_W-1:ACC_W]) ||
		(pmag_q[ACC_W-1:0] > (neg_q ? NEG_LIMIT : POS_LIMIT));

	// accumulator adders
	assign int_sum = acc_num_q + n_ext;
	assign pp_sum  = p1_q + p2_q;

	// truncating remainder takes the dividend sign
	assign rem_signed = gx_q[ACC_W-1] ? (~div_rsp.remainder + ACC_ONE) : div_rsp.remainder;

	// exact quotient by the gcd, with sign and wrap
	assign q_neg = ((state_q == S_QN) ? acc_num_q[ACC_W-1] : acc_den_q[ACC_W-1]) ^ gx_q[ACC_W-1];
	assign q_val = q_neg ? (~div_rsp.quotient + ACC_ONE) : div_rsp.quotient;
	assign q_ovf = !q_neg && div_rsp.quotient[ACC_W-1];

	assign emit_free = !out_valid_q || out_ready;

	// divider requests: euclid steps, then the two reductions
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = mag64(acc_num_q);
		div_req.divisor  = mag64(gx_q);
		case (state_q)
			S_GCD: begin
				if (gy_q != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = mag64(gx_q);
					div_req.divisor  = mag64(gy_q);
				end else if (gx_q != '0) begin
					div_req.start = 1'b1;
				end
			end
			S_QN: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = mag64(acc_den_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	rsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prod_q       <= PROD_NUM_D;
			mstep_q      <= MSTEP_LO;
			have_first_q <= 1'b0;
			ovf_q        <= 1'b0;
			mode_q       <= 1'b0;
			frac_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						frac_q  <= mode_q;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					have_first_q <= 1'b1;
					if (!have_first_q) begin
						state_q <= S_END;
					end else if (frac_q) begin
						prod_q  <= PROD_NUM_D;
						mstep_q <= MSTEP_LO;
						state_q <= S_MUL;
					end else begin
						if (add_ovf(acc_num_q, n_ext, int_sum)) begin
							ovf_q <= 1'b1;
						end
						state_q <= S_END;
					end
				end
				S_MUL: begin
					case (mstep_q)
						MSTEP_LO:  mstep_q <= MSTEP_HI;
						MSTEP_HI:  mstep_q <= MSTEP_SUM;
						MSTEP_SUM: mstep_q <= MSTEP_FIX;
						MSTEP_FIX: begin
							mstep_q <= MSTEP_LO;
							if (p_ovf) begin
								ovf_q <= 1'b1;
							end
							case (prod_q)
								PROD_NUM_D: prod_q <= PROD_DEN_N;
								PROD_DEN_N: prod_q <= PROD_DEN_D;
								default:    state_q <= S_ADD;
							endcase
						end
						default: mstep_q <= MSTEP_LO;
					endcase
				end
				S_ADD: begin
					if (add_ovf(p1_q, p2_q, pp_sum)) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_END;
				end
				S_END: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (frac_q) begin
						state_q <= S_GCD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_GCD: begin
					if (gy_q != '0) begin
						state_q <= S_GREM;
					end else if (gx_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_QN;
					end
				end
				S_GREM: begin
					if (div_rsp.done) begin
						state_q <= S_GCD;
					end
				end
				S_QN: begin
					if (div_rsp.done) begin
						if (q_ovf) begin
							ovf_q <= 1'b1;
						end
						state_q <= S_QD;
					end
				end
				S_QD: begin
					if (div_rsp.done) begin
						if (q_ovf) begin
							ovf_q <= 1'b1;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_free) begin
						out_valid_q  <= 1'b1;
						have_first_q <= 1'b0;
						ovf_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_n_q <= numerator_in;
					item_d_q <= denominator_in;
					last_q   <= last_item;
				end
			end
			S_STEP: begin
				if (!have_first_q) begin
					acc_num_q <= n_ext;
					acc_den_q <= frac_q ? d_ext : ACC_ONE;
				end else if (!frac_q) begin
					acc_num_q <= int_sum;
				end
			end
			S_MUL: begin
				case (mstep_q)
					MSTEP_LO: begin
						mul_q <= mul_p;
						neg_q <= a_sel[ACC_W-1] ^ b_sel[ACC_W-1];
					end
					MSTEP_HI: begin
						low_q <= mul_q;
						mul_q <= mul_p;
					end
					MSTEP_SUM: begin
						pmag_q <= {mul_q, HALF_W'(0)} + MAG_W'(low_q);
					end
					MSTEP_FIX: begin
						case (prod_q)
							PROD_NUM_D: p1_q <= pv;
							PROD_DEN_N: p2_q <= pv;
							default:    acc_den_q <= pv;
						endcase
					end
					default: begin
						mul_q <= mul_q;
					end
				endcase
			end
			S_ADD: begin
				acc_num_q <= pp_sum;
			end
			S_END: begin
				gx_q       <= acc_num_q;
				gy_q       <= acc_den_q;
				res_num_q  <= acc_num_q;
				res_den_q  <= frac_q ? acc_den_q : ACC_ONE;
				res_zdiv_q <= 1'b0;
			end
			S_GCD: begin
				if (gy_q == '0 && gx_q == '0) begin
					res_zdiv_q <= 1'b1;
				end
			end
			S_GREM: begin
				if (div_rsp.done) begin
					gx_q <= gy_q;
					gy_q <= rem_signed;
				end
			end
			S_QN: begin
				if (div_rsp.done) begin
					res_num_q <= q_val;
				end
			end
			S_QD: begin
				if (div_rsp.done) begin
					res_den_q <= q_val;
				end
			end
			S_EMIT: begin
				if (emit_free) begin
					out_num_q  <= res_num_q;
					out_den_q  <= res_den_q;
					out_ovf_q  <= ovf_q;
					out_zdiv_q <= res_zdiv_q;
				end
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	// ports
	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign sum_numerator   = out_num_q;
	assign sum_denominator = out_den_q;
	assign overflow_seen   = out_ovf_q;
	assign zero_divisor    = out_zdiv_q;

	// checks
	`RSA_ASSERT_IMPLY(a_div_start_idle, div_req.start, !div_rsp.busy)
	`RSA_ASSERT_IMPLY(a_zero_div_sum, out_valid && zero_divisor, ~|(sum_numerator | sum_denominator))
	`RSA_ASSERT_IMPLY(a_int_den_one, (state_q == S_EMIT) && !frac_q, res_den_q == ACC_ONE && !res_zdiv_q)
	`RSA_ASSERT_NEXT(a_emit_waits, (state_q == S_EMIT) && out_valid && !out_ready, state_q == S_EMIT)

endmodule

>>> design/rsa_div.sv
// ----------------------------------------------------------------------------
// rsa_div
// unsigned 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rsa_div import rsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = '1;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic [ACC_W-1:0]     dsr_q;
	logic [ACC_W:0]       trial;
	logic                 take;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[ACC_W-1]} - {1'b0, dsr_q};
	assign take  = ~trial[ACC_W];

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[ACC_W-1:0] : {rem_q[ACC_W-2:0], quo_q[ACC_W-1]};
			quo_q <= {quo_q[ACC_W-2:0], take};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> test/rational_sum_accumulator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_sum_accumulator_unit_test
// checks integer and fraction sums beat by beat against a predictor kept in
// the bench, with random idling on both channels, a long output hold-off and
// a mode change in the middle of a sequence
// ----------------------------------------------------------------------------
module rational_sum_accumulator_unit_test import rsa_pkg::*; ();

	localparam int IN_W = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int END_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_GOAL = 850;
	localparam int MAX_REPORTS = 50;

	localparam logic [IN_W-1:0] IN_MIN = 32'h8000_0000;
	localparam logic [IN_W-1:0] IN_MAX = 32'h7fff_ffff;
	localparam logic [IN_W-1:0] IN_NEG_MAX = 32'h8000_0001;
	localparam logic [IN_W-1:0] IN_ALL_ONES = 32'hffff_ffff;
	localparam logic [ACC_W-1:0] WORD_ONE = 64'd1;
	localparam logic [ACC_W-1:0] WORD_POS_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [ACC_W-1:0] WORD_NEG_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [ACC_W-1:0] num;
		logic [ACC_W-1:0] den;
		logic             ovf;
		logic             zdiv;
	} sum_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic signed [IN_W-1:0] numerator_in;
	logic signed [IN_W-1:0] denominator_in;
	logic last_item;
	logic out_valid;
	logic out_ready;
	logic signed [ACC_W-1:0] sum_numerator;
	logic signed [ACC_W-1:0] sum_denominator;
	logic overflow_seen;
	logic zero_divisor;

	// predictor state and mode copy
	logic [ACC_W-1:0] run_num = '0;
	logic [ACC_W-1:0] run_den = WORD_ONE;
	bit run_open = 1'b0;
	bit run_wrapped = 1'b0;
	bit frac_mode = 1'b0;

	sum_t pending_sums[$];
	bit steady = 1'b0;
	int hold_request = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int sums_checked = 0;
	int frac_sums = 0;
	int ovf_sums = 0;
	int zero_sums = 0;

	rational_sum_accumulator_unit #(
		.INPUT_WIDTH(IN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.numerator_in(numerator_in),
		.denominator_in(denominator_in),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sum_numerator(sum_numerator),
		.sum_denominator(sum_denominator),
		.overflow_seen(overflow_seen),
		.zero_divisor(zero_divisor)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// 64-bit helpers; the add and multiply helpers also track wrap
	function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] x);
		return x[ACC_W-1] ? (64'd0 - x) : x;
	endfunction

	function automatic logic [ACC_W-1:0] wrap_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] r;
		r = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && r[ACC_W-1] != a[ACC_W-1])
			run_wrapped = 1'b1;
		return r;
	endfunction

	function automatic logic [ACC_W-1:0] wrap_mul(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [2*ACC_W-1:0] full;
		logic [ACC_W-1:0] ua, ub;
		bit neg;
		ua = abs64(a);
		ub = abs64(b);
		neg = a[ACC_W-1] ^ b[ACC_W-1];
		full = {64'd0, ua} * {64'd0, ub};
		if (ua != 0 && ub != 0 && (full[2*ACC_W-1:ACC_W] != 0
				|| full[ACC_W-1:0] > (neg ? WORD_NEG_MIN : WORD_POS_MAX)))
			run_wrapped = 1'b1;
		return a * b;
	endfunction

	// remainder takes the sign of the dividend
	function automatic logic [ACC_W-1:0] trunc_rem(input logic [ACC_W-1:0] x,
			input logic [ACC_W-1:0] y);
		logic [ACC_W-1:0] r;
		r = abs64(x) % abs64(y);
		return x[ACC_W-1] ? (64'd0 - r) : r;
	endfunction

	function automatic logic [ACC_W-1:0] exact_quot(input logic [ACC_W-1:0] n,
			input logic [ACC_W-1:0] g);
		logic [ACC_W-1:0] q;
		bit neg;
		q = abs64(n) / abs64(g);
		neg = n[ACC_W-1] ^ g[ACC_W-1];
		if (!neg && q[ACC_W-1])
			run_wrapped = 1'b1;
		return neg ? (64'd0 - q) : q;
	endfunction

	// fold one accepted beat into the running sum, returns 1 when a sum is due
	function automatic bit fold_item(input logic [IN_W-1:0] n_raw,
			input logic [IN_W-1:0] d_raw, input bit last, output sum_t sum);
		logic [ACC_W-1:0] n, d, x, y, t, p1, p2;
		bit frac;
		n = {{(ACC_W-IN_W){n_raw[IN_W-1]}}, n_raw};
		d = {{(ACC_W-IN_W){d_raw[IN_W-1]}}, d_raw};
		frac = frac_mode;
		sum = '0;
		if (!run_open) begin
			run_num = n;
			run_den = frac ? d : WORD_ONE;
			run_open = 1'b1;
		end else if (frac) begin
			p1 = wrap_mul(run_num, d);
			p2 = wrap_mul(run_den, n);
			run_num = wrap_add(p1, p2);
			run_den = wrap_mul(run_den, d);
		end else begin
			run_num = wrap_add(run_num, n);
		end
		if (!last)
			return 1'b0;
		if (frac) begin
			// euclid on the raw sum, the gcd sign follows the remainder chain
			x = run_num;
			y = run_den;
			while (y != 0) begin
				t = trunc_rem(x, y);
				x = y;
				y = t;
			end
			if (x == 0) begin
				sum.zdiv = 1'b1;
				sum.num = run_num;
				sum.den = run_den;
				zero_sums++;
			end else begin
				sum.num = exact_quot(run_num, x);
				sum.den = exact_quot(run_den, x);
			end
			frac_sums++;
		end else begin
			sum.num = run_num;
			sum.den = WORD_ONE;
		end
		sum.ovf = run_wrapped;
		if (run_wrapped)
			ovf_sums++;
		run_num = '0;
		run_den = WORD_ONE;
		run_open = 1'b0;
		run_wrapped = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
			input logic [ACC_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s got %h, want %h", $time, what, got, want);
	endtask

	// one input beat, entered and left at a falling edge
	task automatic send_item(input logic [IN_W-1:0] n, input logic [IN_W-1:0] d,
			input bit last);
		int gap;
		sum_t sum;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		numerator_in <= n;
		denominator_in <= d;
		last_item <= last;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		if (fold_item(n, d, last, sum))
			pending_sums.push_back(sum);
		items_sent++;
		@(negedge clk);
	endtask

	// stop sending, wait for every sum, then let the block go quiet
	task automatic drain_sums();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_mode(input bit mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		frac_mode = mode;
	endtask

	function automatic logic [IN_W-1:0] pick_operand(input bit as_den);
		logic [IN_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = IN_MIN;
			1: v = IN_MAX;
			2, 3: v = $urandom;
			default: begin
				v = $urandom_range(1, 24);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		if ($urandom_range(0, as_den ? 31 : 15) == 0)
			v = '0;
		return v;
	endfunction

	// integer mode: extremes, zero, denominators ignored
	task automatic test_integer_sums();
		write_mode(1'b0);
		send_item(IN_MAX, $urandom, 1'b1);
		send_item(IN_MIN, $urandom, 1'b1);
		send_item(IN_MIN, $urandom, 1'b0);
		send_item(IN_MIN, $urandom, 1'b0);
		send_item(IN_ALL_ONES, $urandom, 1'b1);
		send_item('0, '0, 1'b1);
		drain_sums();
	endtask

	// fraction mode: zero gcd, negative denominator, wrap, zero denominator
	task automatic test_fraction_sums();
		write_mode(1'b1);
		send_item('0, '0, 1'b1);
		send_item(32'd6, -32'sd4, 1'b1);
		send_item(32'd1, 32'd2, 1'b0);
		send_item(32'd1, 32'd3, 1'b0);
		send_item(32'd1, 32'd6, 1'b1);
		send_item(IN_MAX, IN_MAX, 1'b0);
		send_item(IN_MAX, IN_MAX, 1'b0);
		send_item(IN_MAX, IN_MAX, 1'b1);
		send_item(IN_MIN, IN_MIN, 1'b1);
		send_item(32'd3, '0, 1'b0);
		send_item(32'd1, 32'd2, 1'b1);
		drain_sums();
	endtask

	// mode switches inside one sequence to bring the numerator to -2^63 over an odd
	// negative denominator, so the gcd is -1 and the reducing division wraps
	task automatic test_division_wrap();
		write_mode(1'b1);
		send_item(IN_MIN, IN_NEG_MAX, 1'b0);
		send_item(IN_MAX, IN_MAX, 1'b0);
		drain_sums();
		write_mode(1'b0);
		send_item(IN_MIN, $urandom, 1'b0);
		send_item(IN_MIN, $urandom, 1'b0);
		send_item(IN_MIN, $urandom, 1'b0);
		send_item(32'd1, $urandom, 1'b0);
		drain_sums();
		write_mode(1'b1);
		send_item('0, 32'd1, 1'b1);
		drain_sums();
	endtask

	// output held off while single-beat sums keep coming, so the block stalls
	task automatic test_backpressure();
		write_mode(1'b0);
		steady = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (10) send_item($urandom, $urandom, 1'b1);
		drain_sums();
		steady = 1'b0;
	endtask

	// phases of well-formed sequences in a random mode, drained between phases
	task automatic test_random_traffic();
		int phase_end;
		int len;
		bit mode;
		while (items_sent < ITEM_GOAL) begin
			mode = 1'($urandom_range(0, 1));
			write_mode(mode);
			steady = ($urandom_range(0, 3) == 0);
			phase_end = items_sent + $urandom_range(30, 60);
			while (items_sent < phase_end) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
					: $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					send_item(pick_operand(1'b0), pick_operand(1'b1), i == len - 1);
			end
			drain_sums();
		end
		steady = 1'b0;
	endtask

	// result side: random stalls, one long hold-off on request, per-field check
	initial begin : result_sink
		int stall;
		sum_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			if (pending_sums.size() == 0) begin
				report_mismatch("beat with no sum pending, numerator", sum_numerator, '0);
			end else begin
				want = pending_sums.pop_front();
				if (sum_numerator !== want.num)
					report_mismatch("sum_numerator", sum_numerator, want.num);
				if (sum_denominator !== want.den)
					report_mismatch("sum_denominator", sum_denominator, want.den);
				if (overflow_seen !== want.ovf)
					report_mismatch("overflow_seen", ACC_W'(overflow_seen),
						ACC_W'(want.ovf));
				if (zero_divisor !== want.zdiv)
					report_mismatch("zero_divisor", ACC_W'(zero_divisor),
						ACC_W'(want.zdiv));
				sums_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		numerator_in = '0;
		denominator_in = '0;
		last_item = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_integer_sums();
		test_fraction_sums();
		test_division_wrap();
		test_backpressure();
		test_random_traffic();
		drain_sums();
		repeat (END_CYCLES) @(negedge clk);
		$display("covered %0d input beats and %0d checked sums, %0d of them fraction sums",
			items_sent, sums_checked, frac_sums);
		$display("%0d sums carried the overflow flag, %0d the zero divisor flag",
			ovf_sums, zero_sums);
		if (mismatch_count == 0)
			$display("[rational_sum_accumulator_unit] OK");
		else
			$display("[rational_sum_accumulator_unit] ERROR");
		$finish;
	end

	// worst case is every beat closing a long gcd, taken several times over
	initial begin
		#100_000_000;
		$display("timeout with %0d sums still pending", pending_sums.size());
		$display("[rational_sum_accumulator_unit] ERROR");
		$finish;
	end

endmodule
